FILE: hdl/mwwt_pkg.sv
// Shared definitions for the memory write watch trigger.
// Register map indexes, field widths and stream packing widths.
// No dependencies.
`timescale 1ns / 1ps

package mwwt_pkg;

   // Register map, one 64-bit slot per register
   typedef enum logic [2:0] {
      REG_RANGE_ENABLE  = 3'd0,
      REG_RANGE_START   = 3'd1,
      REG_RANGE_END     = 3'd2,
      REG_RANGE_LIMIT   = 3'd3,
      REG_VALUE_ENABLE  = 3'd4,
      REG_VALUE_PATTERN = 3'd5,
      REG_VALUE_MASK    = 3'd6,
      REG_VALUE_LIMIT   = 3'd7
   } reg_index_type;

   // Fixed field widths of the stream payloads
   localparam int ADDR_BITS   = 32;
   localparam int LEN_BITS    = 4;
   localparam int DATA_BITS   = 64;
   localparam int OFFSET_BITS = 3;
   localparam int COUNT_BITS  = 32;
   localparam int LIMIT_BITS  = 32;

   // Stream and register port widths
   localparam int REQ_TDATA_BITS = 104;
   localparam int RSP_TDATA_BITS = 136;
   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_DATA_BITS  = 64;

   // Reset values of the register map
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 32'd4096;
   localparam logic [DATA_BITS-1:0]  MASK_RESET  = {DATA_BITS{1'b1}};

endpackage

FILE: hdl/memory_write_watch_trigger.sv
// Memory write watch trigger: address window and masked value watchpoints.
// Each write passes through the input register, then the result register, before its rsp transfer.
// Throughput: one write per cycle; the result register stalls only on rsp_tready low.
// Reset (synchronous, active high) clears both hit counters, empties both stages and
// restores the register map: triggers off, window 0..0, mask all ones, limits 4096.
// Depends on mwwt_pkg.
`timescale 1ns / 1ps

module memory_write_watch_trigger #(
   parameter int ADDR_WIDTH  = 32,
   parameter int COUNT_WIDTH = 32,
   parameter int DATA_BYTES  = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Write stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // tdata: write_address[31:0], write_length[35:32], write_data[99:36], zero pad
   input  logic [mwwt_pkg::REQ_TDATA_BITS-1:0]      req_tdata,
   // tuser: is_main_memory[0]
   input  logic                                     req_tuser,
   // Result stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // tdata: range_hit[0], value_hit[1], value_match_offset[4:2],
   //        value_matched_word[68:5], range_hit_count[100:69],
   //        value_hit_count[132:101], zero pad
   output logic [mwwt_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata,
   // tuser: value_match_is_byte[0]
   output logic                                     rsp_tuser,
   // Register port
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [mwwt_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [mwwt_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [mwwt_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);

   localparam int AW        = (ADDR_WIDTH < mwwt_pkg::ADDR_BITS) ? ADDR_WIDTH
                                                                 : mwwt_pkg::ADDR_BITS;
   localparam int WORD_BITS = 8 * DATA_BYTES;
   localparam int CW_EXT    = (COUNT_WIDTH > mwwt_pkg::LIMIT_BITS) ? COUNT_WIDTH
                                                                   : mwwt_pkg::LIMIT_BITS;
   localparam logic [mwwt_pkg::DATA_BITS-1:0] WORD_MASK =
      {mwwt_pkg::DATA_BITS{1'b1}} >> (mwwt_pkg::DATA_BITS - WORD_BITS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [mwwt_pkg::LEN_BITS-1:0] LEN_MAX = mwwt_pkg::LEN_BITS'(DATA_BYTES);

   // Register map
   logic                                range_enable_ff;
   logic [mwwt_pkg::ADDR_BITS-1:0]      range_start_ff;
   logic [mwwt_pkg::ADDR_BITS-1:0]      range_end_ff;
   logic [mwwt_pkg::LIMIT_BITS-1:0]     range_limit_ff;
   logic                                value_enable_ff;
   logic [mwwt_pkg::DATA_BITS-1:0]      value_pattern_ff;
   logic [mwwt_pkg::DATA_BITS-1:0]      value_mask_ff;
   logic [mwwt_pkg::LIMIT_BITS-1:0]     value_limit_ff;

   // Hit counters
   logic [COUNT_WIDTH-1:0]              range_count_ff, range_count_in;
   logic [COUNT_WIDTH-1:0]              value_count_ff, value_count_in;

   // Input stage
   logic                                in_valid_ff;
   logic [AW-1:0]                       in_addr_ff;
   logic [mwwt_pkg::LEN_BITS-1:0]       in_len_ff;
   logic [mwwt_pkg::DATA_BITS-1:0]      in_data_ff;
   logic                                in_main_ff;

   // Result stage
   logic                                out_valid_ff;
   logic                                out_range_hit_ff, out_range_hit_in;
   logic                                out_value_hit_ff, out_value_hit_in;
   logic                                out_is_byte_ff, out_is_byte_in;
   logic [mwwt_pkg::OFFSET_BITS-1:0]    out_offset_ff, out_offset_in;
   logic [mwwt_pkg::DATA_BITS-1:0]      out_word_ff, out_word_in;
   logic [mwwt_pkg::COUNT_BITS-1:0]     out_range_count_ff;
   logic [mwwt_pkg::COUNT_BITS-1:0]     out_value_count_ff;

   logic                                advance;
   logic                                csr_write;
   mwwt_pkg::reg_index_type             csr_index;

   logic [mwwt_pkg::LEN_BITS-1:0]       len_clip;
   logic                                active;
   logic [mwwt_pkg::DATA_BITS-1:0]      mask_w, pat_w;
   logic                                byte_mode;
   logic [DATA_BYTES-1:0]               lane_hit;
   logic                                byte_found;
   logic [mwwt_pkg::OFFSET_BITS-1:0]    byte_off;
   logic [mwwt_pkg::DATA_BITS-1:0]      data_len;
   logic                                word_match;
   logic                                value_fire;
   logic                                value_may;
   logic [AW:0]                         span_sum;
   logic [AW-1:0]                       span_end;
   logic                                range_fire;
   logic                                range_may;
   logic [CW_EXT-1:0]                   range_count_ext, value_count_ext;

   // Handshakes
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = mwwt_pkg::reg_index_type'(csr_paddr[5:3]);

   // Register read
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         mwwt_pkg::REG_RANGE_ENABLE:  csr_prdata = 64'(range_enable_ff);
         mwwt_pkg::REG_RANGE_START:   csr_prdata = 64'(range_start_ff);
         mwwt_pkg::REG_RANGE_END:     csr_prdata = 64'(range_end_ff);
         mwwt_pkg::REG_RANGE_LIMIT:   csr_prdata = 64'(range_limit_ff);
         mwwt_pkg::REG_VALUE_ENABLE:  csr_prdata = 64'(value_enable_ff);
         mwwt_pkg::REG_VALUE_PATTERN: csr_prdata = value_pattern_ff;
         mwwt_pkg::REG_VALUE_MASK:    csr_prdata = value_mask_ff;
         mwwt_pkg::REG_VALUE_LIMIT:   csr_prdata = 64'(value_limit_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // Register write
   always_ff @(posedge clock) begin
      if (reset) begin
         range_enable_ff  <= 1'b0;
         range_start_ff   <= '0;
         range_end_ff     <= '0;
         range_limit_ff   <= mwwt_pkg::LIMIT_RESET;
         value_enable_ff  <= 1'b0;
         value_pattern_ff <= '0;
         value_mask_ff    <= mwwt_pkg::MASK_RESET;
         value_limit_ff   <= mwwt_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mwwt_pkg::REG_RANGE_ENABLE:  range_enable_ff  <= csr_pwdata[0];
            mwwt_pkg::REG_RANGE_START:   range_start_ff   <= csr_pwdata[31:0];
            mwwt_pkg::REG_RANGE_END:     range_end_ff     <= csr_pwdata[31:0];
            mwwt_pkg::REG_RANGE_LIMIT:   range_limit_ff   <= csr_pwdata[31:0];
            mwwt_pkg::REG_VALUE_ENABLE:  value_enable_ff  <= csr_pwdata[0];
            mwwt_pkg::REG_VALUE_PATTERN: value_pattern_ff <= csr_pwdata;
            mwwt_pkg::REG_VALUE_MASK:    value_mask_ff    <= csr_pwdata;
            mwwt_pkg::REG_VALUE_LIMIT:   value_limit_ff   <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   // Capture the write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_addr_ff <= req_tdata[AW-1:0];
         in_len_ff  <= req_tdata[35:32];
         in_data_ff <= req_tdata[99:36] & WORD_MASK;
         in_main_ff <= req_tuser;
      end
   end

   // Clip the length and gate on main memory
   assign len_clip = (in_len_ff > LEN_MAX) ? LEN_MAX : in_len_ff;
   assign active   = in_main_ff && (len_clip != '0);

   // Value trigger: byte mode when mask and pattern fit in one byte
   assign mask_w    = value_mask_ff & WORD_MASK;
   assign pat_w     = value_pattern_ff & WORD_MASK;
   assign byte_mode = (mask_w[63:8] == '0) && (pat_w[63:8] == '0);

   always_comb begin
      for (int i = 0; i < DATA_BYTES; i++) begin
         lane_hit[i] = ((in_data_ff[8*i +: 8] & mask_w[7:0]) ==
                        (pat_w[7:0] & mask_w[7:0]))
                       && (mwwt_pkg::LEN_BITS'(i) < len_clip);
      end
   end

   // Pick the lowest matching byte
   always_comb begin
      byte_off = '0;
      for (int i = DATA_BYTES - 1; i >= 0; i--) begin
         if (lane_hit[i]) byte_off = mwwt_pkg::OFFSET_BITS'(i);
      end
   end
   assign byte_found = |lane_hit;

   // Drop bytes past the write length
   always_comb begin
      for (int j = 0; j < mwwt_pkg::DATA_BITS / 8; j++) begin
         data_len[8*j +: 8] = (mwwt_pkg::LEN_BITS'(j) < len_clip) ? in_data_ff[8*j +: 8]
                                                                  : 8'h00;
      end
   end

   assign word_match = (in_data_ff & mask_w) == (pat_w & mask_w);
   assign value_fire = active && value_enable_ff && (byte_mode ? byte_found : word_match);

   assign value_count_ext = CW_EXT'(value_count_ff);
   assign value_may       = (value_limit_ff == '0) ||
                            (value_count_ext < CW_EXT'(value_limit_ff));
   assign out_value_hit_in = value_fire && value_may;

   always_comb begin
      out_is_byte_in = 1'b0;
      out_offset_in  = '0;
      out_word_in    = '0;
      if (out_value_hit_in) begin
         if (byte_mode) begin
            out_is_byte_in = 1'b1;
            out_offset_in  = byte_off;
            out_word_in    = data_len >> {byte_off, 3'b000};
         end else begin
            out_word_in    = in_data_ff;
         end
      end
   end

   // Address trigger: span end saturates at the top of the address space
   assign span_sum   = {1'b0, in_addr_ff} + (AW+1)'(len_clip) - (AW+1)'(1);
   assign span_end   = span_sum[AW] ? {AW{1'b1}} : span_sum[AW-1:0];
   assign range_fire = active && range_enable_ff &&
                       (in_addr_ff <= range_end_ff[AW-1:0]) &&
                       (span_end >= range_start_ff[AW-1:0]);

   assign range_count_ext = CW_EXT'(range_count_ff);
   assign range_may       = (range_limit_ff == '0) ||
                            (range_count_ext < CW_EXT'(range_limit_ff));
   assign out_range_hit_in = range_fire && range_may;

   // Next counter values, saturating
   always_comb begin
      range_count_in = range_count_ff;
      value_count_in = value_count_ff;
      if (out_range_hit_in && range_count_ff != COUNT_MAX) begin
         range_count_in = range_count_ff + COUNT_WIDTH'(1);
      end
      if (out_value_hit_in && value_count_ff != COUNT_MAX) begin
         value_count_in = value_count_ff + COUNT_WIDTH'(1);
      end
   end

   // Advance counters; a write of an enable register clears its counter
   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
         value_count_ff <= '0;
      end else begin
         if (csr_write && csr_index == mwwt_pkg::REG_RANGE_ENABLE) begin
            range_count_ff <= '0;
         end else if (in_valid_ff && advance) begin
            range_count_ff <= range_count_in;
         end
         if (csr_write && csr_index == mwwt_pkg::REG_VALUE_ENABLE) begin
            value_count_ff <= '0;
         end else if (in_valid_ff && advance) begin
            value_count_ff <= value_count_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_range_hit_ff   <= out_range_hit_in;
         out_value_hit_ff   <= out_value_hit_in;
         out_is_byte_ff     <= out_is_byte_in;
         out_offset_ff      <= out_offset_in;
         out_word_ff        <= out_word_in;
         out_range_count_ff <= mwwt_pkg::COUNT_BITS'(CW_EXT'(range_count_in));
         out_value_count_ff <= mwwt_pkg::COUNT_BITS'(CW_EXT'(value_count_in));
      end
   end

   // Pack the result transfer
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_is_byte_ff;
   assign rsp_tdata  = {3'b000, out_value_count_ff, out_range_count_ff, out_word_ff,
                        out_offset_ff, out_value_hit_ff, out_range_hit_ff};

endmodule

FILE: test/memory_write_watch_trigger_test.sv
// Self-checking test of memory_write_watch_trigger: predicts every result transfer from a
// mirror of the register map and the two hit counters, under random stream backpressure.
// Depends on mwwt_pkg and memory_write_watch_trigger.
`timescale 1ns / 1ps

module memory_write_watch_trigger_test;

   typedef struct {
      logic [mwwt_pkg::ADDR_BITS-1:0] address;
      logic [mwwt_pkg::LEN_BITS-1:0]  length;
      logic [mwwt_pkg::DATA_BITS-1:0] data;
      logic                           main_mem;
   } write_item_type;

   typedef struct {
      logic                             range_hit;
      logic                             value_hit;
      logic                             is_byte;
      logic [mwwt_pkg::OFFSET_BITS-1:0] offset;
      logic [mwwt_pkg::DATA_BITS-1:0]   word;
      logic [mwwt_pkg::COUNT_BITS-1:0]  range_count;
      logic [mwwt_pkg::COUNT_BITS-1:0]  value_count;
   } watch_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [mwwt_pkg::REQ_TDATA_BITS-1:0]   req_tdata = '0;
   logic                                  req_tuser = 1'b0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [mwwt_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic                                  rsp_tuser;
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [mwwt_pkg::CSR_ADDR_BITS-1:0]    csr_paddr = '0;
   logic [mwwt_pkg::CSR_DATA_BITS-1:0]    csr_pwdata = '0;
   logic [mwwt_pkg::CSR_DATA_BITS-1:0]    csr_prdata;
   logic                                  csr_pready;

   memory_write_watch_trigger DUT (.*);

   // Mirror of the register map and hit counters
   logic                            win_enable = 1'b0;
   logic [mwwt_pkg::ADDR_BITS-1:0]  win_start = '0;
   logic [mwwt_pkg::ADDR_BITS-1:0]  win_end = '0;
   logic [mwwt_pkg::LIMIT_BITS-1:0] win_limit = mwwt_pkg::LIMIT_RESET;
   logic                            val_enable = 1'b0;
   logic [mwwt_pkg::DATA_BITS-1:0]  val_pattern = '0;
   logic [mwwt_pkg::DATA_BITS-1:0]  val_mask = mwwt_pkg::MASK_RESET;
   logic [mwwt_pkg::LIMIT_BITS-1:0] val_limit = mwwt_pkg::LIMIT_RESET;
   logic [mwwt_pkg::COUNT_BITS-1:0] win_count = '0;
   logic [mwwt_pkg::COUNT_BITS-1:0] val_count = '0;

   write_item_type   pending_writes[$];
   write_item_type   write_in_flight;
   watch_result_type expected_results[$];

   int send_idle_pct = 17;
   int recv_idle_pct = 58;
   int stall_requests = 0;
   int stall_served = 0;
   int stall_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic counter_open(logic [mwwt_pkg::COUNT_BITS-1:0] count,
                                         logic [mwwt_pkg::LIMIT_BITS-1:0] limit);
      return limit == '0 || count < limit;
   endfunction

   // Saturate at all ones
   function automatic logic [mwwt_pkg::COUNT_BITS-1:0] count_up(
      logic [mwwt_pkg::COUNT_BITS-1:0] count);
      return (&count) ? count : count + mwwt_pkg::COUNT_BITS'(1);
   endfunction

   // Work out the result of one write and advance the hit counters
   function automatic watch_result_type predict_watch(write_item_type w);
      watch_result_type                 r;
      int unsigned                      len;
      int unsigned                      i;
      logic [mwwt_pkg::ADDR_BITS:0]     span_end;
      logic [7:0]                       lane;
      logic [mwwt_pkg::DATA_BITS-1:0]   ones;
      logic                             matched;
      logic                             m_byte;
      logic [mwwt_pkg::OFFSET_BITS-1:0] m_off;
      logic [mwwt_pkg::DATA_BITS-1:0]   m_word;
      r = '{default: '0};
      ones = '1;
      matched = 1'b0;
      m_byte = 1'b0;
      m_off = '0;
      m_word = '0;
      len = (w.length > 4'd8) ? 32'd8 : 32'(w.length);

      if (w.main_mem && len != 0 && val_enable) begin
         if (val_mask <= 64'hff && val_pattern <= 64'hff) begin
            // byte mode: first matching lane inside the write
            for (i = 0; i < len; i++) begin
               lane = w.data[8*i +: 8];
               if (!matched && (lane & val_mask[7:0]) == (val_pattern[7:0] & val_mask[7:0]))
               begin
                  matched = 1'b1;
                  m_byte = 1'b1;
                  m_off = i[mwwt_pkg::OFFSET_BITS-1:0];
                  m_word = (w.data >> (8*i)) & (ones >> (64 - 8*(len - i)));
               end
            end
         end else if ((w.data & val_mask) == (val_pattern & val_mask)) begin
            matched = 1'b1;
            m_word = w.data;
         end
         if (matched && counter_open(val_count, val_limit)) begin
            val_count = count_up(val_count);
            r.value_hit = 1'b1;
            r.is_byte = m_byte;
            r.offset = m_off;
            r.word = m_word;
         end
      end

      if (w.main_mem && len != 0 && win_enable && counter_open(win_count, win_limit)) begin
         // clamp the span end at the top of the address space
         span_end = {1'b0, w.address} + (mwwt_pkg::ADDR_BITS+1)'(len)
                    - (mwwt_pkg::ADDR_BITS+1)'(1);
         if (span_end[mwwt_pkg::ADDR_BITS])
            span_end = {1'b0, {mwwt_pkg::ADDR_BITS{1'b1}}};
         if (w.address <= win_end && span_end >= {1'b0, win_start}) begin
            win_count = count_up(win_count);
            r.range_hit = 1'b1;
         end
      end

      r.range_count = win_count;
      r.value_count = val_count;
      return r;
   endfunction

   function automatic void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
   endfunction

   task automatic check_result(watch_result_type want);
      if (rsp_tdata[0] !== want.range_hit)
         report_mismatch("range_hit", 64'(want.range_hit), 64'(rsp_tdata[0]));
      if (rsp_tdata[1] !== want.value_hit)
         report_mismatch("value_hit", 64'(want.value_hit), 64'(rsp_tdata[1]));
      if (rsp_tuser !== want.is_byte)
         report_mismatch("value_match_is_byte", 64'(want.is_byte), 64'(rsp_tuser));
      if (rsp_tdata[4:2] !== want.offset)
         report_mismatch("value_match_offset", 64'(want.offset), 64'(rsp_tdata[4:2]));
      if (rsp_tdata[68:5] !== want.word)
         report_mismatch("value_matched_word", want.word, rsp_tdata[68:5]);
      if (rsp_tdata[100:69] !== want.range_count)
         report_mismatch("range_hit_count", 64'(want.range_count), 64'(rsp_tdata[100:69]));
      if (rsp_tdata[132:101] !== want.value_count)
         report_mismatch("value_hit_count", 64'(want.value_count), 64'(rsp_tdata[132:101]));
   endtask

   // Write driver: offer the next pending write, predict at each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_watch(write_in_flight));
         if (!req_tvalid || req_tready) begin
            if (pending_writes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               write_in_flight = pending_writes.pop_front();
               req_tdata <= {{(mwwt_pkg::REQ_TDATA_BITS-100){1'b0}}, write_in_flight.data,
                             write_in_flight.length, write_in_flight.address};
               req_tuser <= write_in_flight.main_mem;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each transfer, drive backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got %0h", $time, rsp_tdata);
               mismatches++;
            end else begin
               check_result(expected_results.pop_front());
            end
         end
         // hold off for a long stretch on request
         if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            stall_left = 80;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 2000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Setup and access cycle; mirror the write at the access edge
   task automatic write_reg(mwwt_pkg::reg_index_type index, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         mwwt_pkg::REG_RANGE_ENABLE: begin
            win_enable = value[0];
            win_count = '0;
         end
         mwwt_pkg::REG_RANGE_START:   win_start = value[mwwt_pkg::ADDR_BITS-1:0];
         mwwt_pkg::REG_RANGE_END:     win_end = value[mwwt_pkg::ADDR_BITS-1:0];
         mwwt_pkg::REG_RANGE_LIMIT:   win_limit = value[mwwt_pkg::LIMIT_BITS-1:0];
         mwwt_pkg::REG_VALUE_ENABLE: begin
            val_enable = value[0];
            val_count = '0;
         end
         mwwt_pkg::REG_VALUE_PATTERN: val_pattern = value;
         mwwt_pkg::REG_VALUE_MASK:    val_mask = value;
         mwwt_pkg::REG_VALUE_LIMIT:   val_limit = value[mwwt_pkg::LIMIT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_watch(logic r_en, logic [31:0] r_start, logic [31:0] r_end,
                                logic [31:0] r_limit, logic v_en, logic [63:0] v_pattern,
                                logic [63:0] v_mask, logic [31:0] v_limit);
      write_reg(mwwt_pkg::REG_RANGE_START, 64'(r_start));
      write_reg(mwwt_pkg::REG_RANGE_END, 64'(r_end));
      write_reg(mwwt_pkg::REG_RANGE_LIMIT, 64'(r_limit));
      write_reg(mwwt_pkg::REG_RANGE_ENABLE, 64'(r_en));
      write_reg(mwwt_pkg::REG_VALUE_PATTERN, v_pattern);
      write_reg(mwwt_pkg::REG_VALUE_MASK, v_mask);
      write_reg(mwwt_pkg::REG_VALUE_LIMIT, 64'(v_limit));
      write_reg(mwwt_pkg::REG_VALUE_ENABLE, 64'(v_en));
   endtask

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(4))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return $urandom_range(40, 2);
         3:       return 32'hffff_ffff;
         default: return 32'd4096;
      endcase
   endfunction

   task automatic program_random_watch();
      logic [31:0] s;
      logic [31:0] e;
      logic [63:0] pat;
      logic [63:0] mask;
      case ($urandom_range(3))
         0:       s = $urandom();
         1:       s = 32'd0;
         2:       s = 32'hffff_ffff - $urandom_range(64);
         default: s = $urandom_range(4096);
      endcase
      case ($urandom_range(4))
         0:       e = s + $urandom_range(16);
         1:       e = s + $urandom_range(4096);
         2:       e = 32'hffff_ffff;
         3:       e = s - $urandom_range(16, 1);
         default: e = s;
      endcase
      case ($urandom_range(4))
         0: begin
            mask = 64'($urandom_range(255));
            pat = 64'($urandom_range(255));
         end
         1: begin
            mask = {$urandom(), $urandom()} & {$urandom(), $urandom()};
            pat = {$urandom(), $urandom()};
         end
         2: begin
            mask = '1;
            pat = {$urandom(), $urandom()};
         end
         3: begin
            // pattern above a byte forces word mode under a small mask
            mask = 64'($urandom_range(255));
            pat = {$urandom(), $urandom()} | 64'h100;
         end
         default: begin
            mask = '0;
            pat = '0;
         end
      endcase
      program_watch($urandom_range(5) != 0, s, e, pick_limit(),
                    $urandom_range(5) != 0, pat, mask, pick_limit());
   endtask

   function automatic void queue_write(logic [31:0] address, logic [3:0] length,
                                       logic [63:0] data, logic main_mem);
      write_item_type w;
      w.address = address;
      w.length = length;
      w.data = data;
      w.main_mem = main_mem;
      pending_writes.push_back(w);
   endfunction

   // Random write aimed at the current window and pattern
   function automatic void queue_random_write();
      logic [31:0] address;
      logic [3:0]  length;
      logic [63:0] data;
      int unsigned lane;
      case ($urandom_range(3))
         0:       address = $urandom();
         1:       address = win_start + $urandom_range(24) - 32'd12;
         2:       address = win_end + $urandom_range(24) - 32'd12;
         default: address = 32'hffff_ffff - $urandom_range(12);
      endcase
      length = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
      data = {$urandom(), $urandom()};
      if ($urandom_range(2) != 0) begin
         if (val_mask <= 64'hff && val_pattern <= 64'hff) begin
            lane = $urandom_range(7);
            data[8*lane +: 8] = (val_pattern[7:0] & val_mask[7:0]) |
                                (8'($urandom()) & ~val_mask[7:0]);
         end else begin
            data = (data & ~val_mask) | (val_pattern & val_mask);
         end
      end
      queue_write(address, length, data, $urandom_range(9) != 0);
   endfunction

   // Wait at the falling edge so the driver's updates have settled
   task automatic wait_drained();
      while (pending_writes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int batch;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Byte mode, small window, no limits
      program_watch(1'b1, 32'h1000, 32'h100f, 32'd0, 1'b1, 64'hab, 64'hff, 32'd0);
      queue_write(32'h0000_0ff8, 4'd8, 64'h0, 1'b1);
      queue_write(32'h0000_0ff9, 4'd8, 64'h00ab_0000_0000_0000, 1'b1);
      queue_write(32'h0000_100f, 4'd1, 64'hab, 1'b1);
      queue_write(32'h0000_1010, 4'd1, 64'hab, 1'b1);
      queue_write(32'hffff_fffc, 4'd8, 64'hab00_0000_0000_0000, 1'b1);
      queue_write(32'h0000_1000, 4'd0, 64'hab, 1'b1);
      queue_write(32'h0000_1000, 4'd15, 64'hab00_0000_0000_0000, 1'b1);
      queue_write(32'h0000_1000, 4'd8, 64'hab, 1'b0);
      queue_write(32'h0000_1000, 4'd7, 64'hab00_0000_0000_0000, 1'b1);
      queue_write(32'h0000_1004, 4'd4, 64'hffff_ffff_ffff_ffff, 1'b1);
      wait_drained();

      // Word mode, window end below start, limits of two
      program_watch(1'b1, 32'h2000, 32'h1000, 32'd2, 1'b1, 64'hdead_beef_0000_0000,
                    64'hffff_ffff_0000_0000, 32'd2);
      queue_write(32'h0000_1800, 4'd4, 64'hdead_beef_1234_5678, 1'b1);
      queue_write(32'h0000_0800, 4'd8, 64'hdead_beef_0000_0000, 1'b1);
      queue_write(32'h0000_0ffc, 4'd8, 64'hdead_beef_ffff_ffff, 1'b1);
      queue_write(32'h0000_0000, 4'd8, 64'hdead_beef_0000_0001, 1'b1);
      wait_drained();

      // Window at the top, pattern above a byte with a small mask
      program_watch(1'b1, 32'hffff_fff0, 32'hffff_ffff, 32'd1, 1'b1, 64'h1ff, 64'h0f,
                    32'd0);
      queue_write(32'hffff_fff8, 4'd8, 64'h0f, 1'b1);
      queue_write(32'hffff_ffff, 4'd8, 64'h1f, 1'b1);
      queue_write(32'h0000_0000, 4'd1, 64'h0, 1'b1);
      wait_drained();

      // Zero mask matches the first lane; range trigger off
      program_watch(1'b0, 32'h0, 32'h0, 32'hffff_ffff, 1'b1, 64'h0, 64'h0, 32'hffff_ffff);
      queue_write(32'h0000_0010, 4'd8, 64'h0123_4567_89ab_cdef, 1'b1);
      queue_write(32'h0000_0010, 4'd3, 64'h0123_4567_89ab_cdef, 1'b1);
      queue_write(32'h0000_0010, 4'd9, 64'hfedc_ba98_7654_3210, 1'b1);
      wait_drained();

      // Random batches under three backpressure profiles
      for (batch = 0; batch < 13; batch++) begin
         if (batch == 5) begin
            send_idle_pct = 58;
            recv_idle_pct = 17;
         end
         if (batch == 10) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_random_watch();
         for (n = 0; n < 50; n++)
            queue_random_write();
         if (batch == 2 || batch == 11)
            stall_requests++;
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
